FILE: hdl/scba_pkg.sv
// Package for the size-class block allocator.
// Types, codes and fixed widths shared by scba_decide and the top level; no dependencies.
package scba_pkg;

  localparam int NumClasses = 4;
  localparam int ClsW       = 2;
  localparam int SizeW      = 16;
  localparam int CntrW      = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int CountW     = 3;

  typedef enum logic [1:0] {
    ModeAcquire = 2'd0,
    ModeRelease = 2'd1,
    ModeStats   = 2'd2,
    ModeUnused  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StDisabled  = 3'd1,
    StNoFit     = 3'd2,
    StExhausted = 3'd3,
    StBadClass  = 3'd4,
    StNoneOut   = 3'd5
  } status_e;

  localparam logic [CfgIdxW-1:0] CfgClassCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgClassSize0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgClassSize1 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgClassSize2 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgClassSize3 = 3'd4;

  typedef logic [SizeW-1:0] size_t;

  // Outcome of one word, handed from the decision logic to the state update.
  typedef struct packed {
    status_e         status;
    logic            rep;    // a class is reported
    logic [ClsW-1:0] cls;
    logic            pop;
    logic            push;
    logic            fail;
  } dec_t;

endpackage

FILE: hdl/scba_stack_mem.sv
// Free-stack storage: one write port, one read port, registered read data.
// Depends on nothing.
module scba_stack_mem #(
  parameter int AddrW = 10,
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/scba_decide.sv
// Per-word decision: class fit search, range checks and status selection.
// Depends on scba_pkg.
module scba_decide import scba_pkg::*; (
  input  mode_e              mode_i,
  input  logic [SizeW-1:0]   req_i,
  input  logic [ClsW-1:0]    cls_i,
  input  logic [CountW-1:0]  class_count_i,
  input  size_t              sizes_i [NumClasses],
  input  logic [NumClasses-1:0] full_i,
  input  logic [NumClasses-1:0] empty_i,
  output dec_t               dec_o
);

  logic [CountW-1:0]     n_act;
  logic [NumClasses-1:0] fit;
  logic [ClsW-1:0]       fit_cls;
  logic                  cls_bad;

  assign n_act   = (class_count_i > CountW'(NumClasses)) ? CountW'(NumClasses) : class_count_i;
  assign cls_bad = ({1'b0, cls_i} >= n_act);

  // all class compares in parallel, lowest fitting class wins
  always_comb begin
    fit     = '0;
    fit_cls = '0;
    for (int c = 0; c < NumClasses; c++) begin
      fit[c] = (CountW'(c) < n_act) && (sizes_i[c] >= req_i);
    end
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (fit[c]) begin
        fit_cls = ClsW'(c);
      end
    end
  end

  always_comb begin
    dec_o        = '0;
    dec_o.status = StDisabled;
    case (mode_i)
      ModeAcquire: begin
        if (n_act == '0 || req_i == '0) begin
          dec_o.status = StDisabled;
        end else if (fit == '0) begin
          dec_o.status = StNoFit;
        end else if (full_i[fit_cls]) begin
          dec_o.status = StExhausted;
          dec_o.rep    = 1'b1;
          dec_o.cls    = fit_cls;
          dec_o.fail   = 1'b1;
        end else begin
          dec_o.status = StOk;
          dec_o.rep    = 1'b1;
          dec_o.cls    = fit_cls;
          dec_o.pop    = 1'b1;
        end
      end
      ModeRelease: begin
        if (cls_bad) begin
          dec_o.status = StBadClass;
        end else if (empty_i[cls_i]) begin
          dec_o.status = StNoneOut;
          dec_o.rep    = 1'b1;
          dec_o.cls    = cls_i;
        end else begin
          dec_o.status = StOk;
          dec_o.rep    = 1'b1;
          dec_o.cls    = cls_i;
          dec_o.push   = 1'b1;
        end
      end
      ModeStats: begin
        if (cls_bad) begin
          dec_o.status = StBadClass;
        end else begin
          dec_o.status = StOk;
          dec_o.rep    = 1'b1;
          dec_o.cls    = cls_i;
        end
      end
      default: begin
        dec_o.status = StDisabled;
      end
    endcase
  end

endmodule

FILE: hdl/size_class_block_allocator.sv
// Size-class block allocator top level: input register, decision, class state,
// free-stack memory and result register. Depends on scba_pkg, scba_decide, scba_stack_mem.
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+-----------------------------
//   in      | in_valid_i / in_ready_o                   | request word (mode, size, ...)
//   out     | out_valid_o / out_ready_i                 | result word (status, counters)
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | register write, no wait
//
// One word per cycle sustained while result words are taken; a request passes the input
// register, then the result register together with the registered stack read.
// Throughput is set by the single free-stack memory port pair: one pop or one push a word.
// Reset clears counters and config at once; there is no clearing pass over the stack,
// the peak count per class marks which stack slots were never written and need no read.
// A stalled result holds the pipe: the input register takes one more word, then in_ready_o
// stays low until the result word is taken.
module size_class_block_allocator import scba_pkg::*; #(
  parameter int BLOCKS_PER_CLASS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  // request words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [SizeW-1:0]      request_size_i,
  input  logic [ClsW-1:0]       class_in_i,
  input  logic [$clog2(BLOCKS_PER_CLASS)-1:0]   block_in_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [ClsW-1:0]       class_out_o,
  output logic [$clog2(BLOCKS_PER_CLASS)-1:0]   block_out_o,
  output logic [$clog2(BLOCKS_PER_CLASS+1)-1:0] in_use_o,
  output logic [$clog2(BLOCKS_PER_CLASS+1)-1:0] peak_in_use_o,
  output logic [SizeW-1:0]      size_out_o,
  output logic [CntrW-1:0]      acquires_total_o,
  output logic [CntrW-1:0]      releases_total_o,
  output logic [CntrW-1:0]      failures_total_o
);

  localparam int BlkW  = $clog2(BLOCKS_PER_CLASS);
  localparam int CntW  = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int AddrW = ClsW + BlkW;

  // ---------------- configuration registers ----------------
  logic [CountW-1:0] class_count_q;
  size_t             size_q [NumClasses];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= '0;
      for (int c = 0; c < NumClasses; c++) begin
        size_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClassCount: class_count_q <= cfg_data_i[CountW-1:0];
        CfgClassSize0: size_q[0]     <= cfg_data_i[SizeW-1:0];
        CfgClassSize1: size_q[1]     <= cfg_data_i[SizeW-1:0];
        CfgClassSize2: size_q[2]     <= cfg_data_i[SizeW-1:0];
        CfgClassSize3: size_q[3]     <= cfg_data_i[SizeW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic              a_valid_q;
  mode_e             a_mode_q;
  logic [SizeW-1:0]  a_req_q;
  logic [ClsW-1:0]   a_cls_q;
  logic [BlkW-1:0]   a_blk_q;
  logic              o_valid_q;
  logic              advance;
  logic              in_take;

  assign advance    = a_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
      if (advance) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_mode_q <= mode_e'(mode_i);
      a_req_q  <= request_size_i;
      a_cls_q  <= class_in_i;
      a_blk_q  <= block_in_i;
    end
  end

  // ---------------- class state ----------------
  logic [CntW-1:0]  out_q  [NumClasses];
  logic [CntW-1:0]  peak_q [NumClasses];
  logic [CntrW-1:0] acq_q  [NumClasses];
  logic [CntrW-1:0] rel_q  [NumClasses];
  logic [CntrW-1:0] fail_q [NumClasses];

  logic [NumClasses-1:0] full;
  logic [NumClasses-1:0] empty;
  dec_t                  dec;

  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      full[c]  = (out_q[c] == CntW'(BLOCKS_PER_CLASS));
      empty[c] = (out_q[c] == '0);
    end
  end

  scba_decide u_decide (
    .mode_i        (a_mode_q),
    .req_i         (a_req_q),
    .cls_i         (a_cls_q),
    .class_count_i (class_count_q),
    .sizes_i       (size_q),
    .full_i        (full),
    .empty_i       (empty),
    .dec_o         (dec)
  );

  // values of the chosen class after this word
  logic [CntW-1:0]  out_cur, peak_cur, out_nx, peak_nx;
  logic [CntrW-1:0] acq_nx, rel_nx, fail_nx;

  assign out_cur  = out_q[dec.cls];
  assign peak_cur = peak_q[dec.cls];

  always_comb begin
    out_nx = out_cur;
    if (dec.pop) begin
      out_nx = out_cur + CntW'(1);
    end else if (dec.push) begin
      out_nx = out_cur - CntW'(1);
    end
    peak_nx = (dec.pop && out_nx > peak_cur) ? out_nx : peak_cur;
    acq_nx  = acq_q[dec.cls]  + CntrW'(dec.pop);
    rel_nx  = rel_q[dec.cls]  + CntrW'(dec.push);
    fail_nx = fail_q[dec.cls] + CntrW'(dec.fail);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumClasses; c++) begin
        out_q[c]  <= '0;
        peak_q[c] <= '0;
        acq_q[c]  <= '0;
        rel_q[c]  <= '0;
        fail_q[c] <= '0;
      end
    end else if (advance && dec.rep) begin
      out_q[dec.cls]  <= out_nx;
      peak_q[dec.cls] <= peak_nx;
      acq_q[dec.cls]  <= acq_nx;
      rel_q[dec.cls]  <= rel_nx;
      fail_q[dec.cls] <= fail_nx;
    end
  end

  // ---------------- free stack ----------------
  // Stack top of a class sits at slot B-1-outstanding. A slot below the deepest point
  // ever reached (peak) was never written; its block index is its own slot number.
  logic [BlkW-1:0]  pos_pop, pos_push;
  logic             fresh;
  logic [AddrW-1:0] mem_addr;
  logic [BlkW-1:0]  mem_rdata;

  assign pos_pop  = BlkW'(CntW'(BLOCKS_PER_CLASS - 1) - out_cur);
  assign pos_push = BlkW'(CntW'(BLOCKS_PER_CLASS) - out_cur);
  assign fresh    = (out_cur >= peak_cur);
  assign mem_addr = dec.pop ? {dec.cls, pos_pop} : {dec.cls, pos_push};

  scba_stack_mem #(
    .AddrW (AddrW),
    .DataW (BlkW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (advance && dec.push),
    .waddr_i (mem_addr),
    .wdata_i (a_blk_q),
    .re_i    (advance && dec.pop && !fresh),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // ---------------- result register ----------------
  status_e          r_status_q;
  logic [ClsW-1:0]  r_cls_q;
  logic [BlkW-1:0]  r_blk_q;
  logic             r_from_mem_q;
  logic [CntW-1:0]  r_use_q, r_peak_q;
  logic [SizeW-1:0] r_size_q;
  logic [CntrW-1:0] r_acq_q, r_rel_q, r_fail_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r_status_q   <= dec.status;
      r_from_mem_q <= dec.pop && !fresh;
      r_blk_q      <= (dec.pop && fresh) ? pos_pop : '0;
      if (dec.rep) begin
        r_cls_q  <= dec.cls;
        r_use_q  <= out_nx;
        r_peak_q <= peak_nx;
        r_size_q <= size_q[dec.cls];
        r_acq_q  <= acq_nx;
        r_rel_q  <= rel_nx;
        r_fail_q <= fail_nx;
      end else begin
        r_cls_q  <= '0;
        r_use_q  <= '0;
        r_peak_q <= '0;
        r_size_q <= '0;
        r_acq_q  <= '0;
        r_rel_q  <= '0;
        r_fail_q <= '0;
      end
    end
  end

  assign out_valid_o      = o_valid_q;
  assign status_o         = r_status_q;
  assign class_out_o      = r_cls_q;
  assign block_out_o      = r_from_mem_q ? mem_rdata : r_blk_q;
  assign in_use_o         = r_use_q;
  assign peak_in_use_o    = r_peak_q;
  assign size_out_o       = r_size_q;
  assign acquires_total_o = r_acq_q;
  assign releases_total_o = r_rel_q;
  assign failures_total_o = r_fail_q;

  // ---------------- assertions ----------------
  a_use_below_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_use_o <= peak_in_use_o)
    else $error("in_use above peak");

  a_exhausted_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StExhausted |-> in_use_o == CntW'(BLOCKS_PER_CLASS))
    else $error("exhausted with free blocks left");

  a_unreported_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StDisabled || status_o == StNoFit || status_o == StBadClass)
    |-> class_out_o == '0 && acquires_total_o == '0 && block_out_o == '0)
    else $error("class fields set without a reported class");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> $onehot0({dec.pop, dec.push, dec.fail}))
    else $error("more than one stack action for one word");

endmodule
